### rtl/tda_pkg.sv
`timescale 1ns / 1ps

package tda_pkg;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_ELEMENT_BITS    = 3'd0;
  localparam logic [2:0] REG_MICRO_MODE      = 3'd1;
  localparam logic [2:0] REG_ARRAY_CLASS     = 3'd2;
  localparam logic [2:0] REG_TILE_DEPTH      = 3'd3;
  localparam logic [2:0] REG_ROW_TILES       = 3'd4;
  localparam logic [2:0] REG_SLICE_TILES     = 3'd5;
  localparam logic [2:0] REG_TILE_SIZE_BYTES = 3'd6;

  // Field widths
  localparam int COORD_W   = 14;
  localparam int Z_W       = 13;
  localparam int TILE_SH   = 3;                  // log2 of the micro tile side
  localparam int TCOORD_W  = COORD_W - TILE_SH;  // tile column / row
  localparam int IDX_W     = 9;
  localparam int EB_W      = 8;
  localparam int DEPTH_W   = 3;
  localparam int ROWT_W    = 12;
  localparam int SLICET_W  = 23;
  localparam int TSB_W     = 14;
  localparam int BIT_OFF_W = 51;
  localparam int BYTE_OFF_W = 48;

  // Micro tile modes
  localparam logic [2:0] MODE_DISPLAY = 3'd0;
  localparam logic [2:0] MODE_THIN    = 3'd1;
  localparam logic [2:0] MODE_DEPTH   = 3'd2;
  localparam logic [2:0] MODE_THICK   = 3'd3;
  localparam logic [2:0] MODE_ROTATED = 3'd4;

  // Array mode classes
  localparam logic [1:0] CLASS_THIN   = 2'd0;
  localparam logic [1:0] CLASS_THICK  = 2'd1;
  localparam logic [1:0] CLASS_XTHICK = 2'd2;

  // Element sizes
  localparam logic [7:0] ELEM_8   = 8'd8;
  localparam logic [7:0] ELEM_16  = 8'd16;
  localparam logic [7:0] ELEM_32  = 8'd32;
  localparam logic [7:0] ELEM_64  = 8'd64;
  localparam logic [7:0] ELEM_128 = 8'd128;

  typedef struct packed {
    logic [EB_W-1:0]     element_bits;
    logic [2:0]          micro_mode;
    logic [1:0]          array_class;
    logic [DEPTH_W-1:0]  tile_depth;
    logic [ROWT_W-1:0]   row_tiles;
    logic [SLICET_W-1:0] slice_tiles;
    logic [TSB_W-1:0]    tile_size_bytes;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             bad;
  } swz_t;

  // One restoring division step with a 3-bit divisor: returns {quotient bit, remainder}
  function automatic logic [3:0] div_step(input logic [2:0] rem, input logic zb,
                                          input logic [2:0] d);
    logic [3:0] t;
    logic [3:0] diff;
    t = {rem, zb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[2:0]};
    end else begin
      return {1'b0, t[2:0]};
    end
  endfunction

  // Element index inside the micro tile
  function automatic swz_t swizzle(input logic [2:0] x, input logic [2:0] y,
                                   input logic [2:0] z, input logic [EB_W-1:0] eb,
                                   input logic [2:0] mode, input logic [1:0] cls);
    swz_t r;
    logic thick_arr;
    logic xthick;
    r = '0;
    thick_arr = (cls == CLASS_THICK) || (cls == CLASS_XTHICK);
    xthick = (cls == CLASS_XTHICK);
    if (mode == MODE_DISPLAY) begin
      if (eb == ELEM_8) begin
        r.idx = {3'b000, y[2], y[0], y[1], x[2], x[1], x[0]};
      end else if (eb == ELEM_16) begin
        r.idx = {3'b000, y[2], y[1], y[0], x[2], x[1], x[0]};
      end else if (eb == ELEM_32) begin
        r.idx = {3'b000, y[2], y[1], x[2], y[0], x[1], x[0]};
      end else if (eb == ELEM_64) begin
        r.idx = {3'b000, y[2], y[1], x[2], x[1], y[0], x[0]};
      end else begin
        r.bad = 1'b1;
      end
    end else if ((mode == MODE_THIN) || (mode == MODE_DEPTH)) begin
      r.idx = {xthick & z[2], thick_arr & z[1], thick_arr & z[0],
               y[2], x[2], y[1], x[1], y[0], x[0]};
    end else if (mode == MODE_THICK) begin
      if (!thick_arr) begin
        r.bad = 1'b1;
      end else begin
        r.idx[8] = xthick & z[2];
        if ((eb == ELEM_8) || (eb == ELEM_16)) begin
          r.idx[7:0] = {y[2], x[2], z[1], z[0], y[1], x[1], y[0], x[0]};
        end else if (eb == ELEM_32) begin
          r.idx[7:0] = {y[2], x[2], z[1], y[1], z[0], x[1], y[0], x[0]};
        end else if ((eb == ELEM_64) || (eb == ELEM_128)) begin
          r.idx[7:0] = {y[2], x[2], z[1], y[1], x[1], z[0], y[0], x[0]};
        end else begin
          r.bad = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

### rtl/tda_regs.sv
`timescale 1ns / 1ps

module tda_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tda_pkg::ADDR_W-1:0]  paddr,
  input  logic [tda_pkg::DATA_W-1:0]  pwdata,
  output logic [tda_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tda_pkg::cfg_t               cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.element_bits    <= tda_pkg::ELEM_32;
      cfg.micro_mode      <= tda_pkg::MODE_THIN;
      cfg.array_class     <= tda_pkg::CLASS_THIN;
      cfg.tile_depth      <= 3'd1;
      cfg.row_tiles       <= 12'd1;
      cfg.slice_tiles     <= 23'd1;
      cfg.tile_size_bytes <= 14'd256;
    end else if (wr_en) begin
      unique case (reg_idx)
        tda_pkg::REG_ELEMENT_BITS:    cfg.element_bits    <= pwdata[7:0];
        tda_pkg::REG_MICRO_MODE:      cfg.micro_mode      <= pwdata[2:0];
        tda_pkg::REG_ARRAY_CLASS:     cfg.array_class     <= pwdata[1:0];
        tda_pkg::REG_TILE_DEPTH:      cfg.tile_depth      <= pwdata[2:0];
        tda_pkg::REG_ROW_TILES:       cfg.row_tiles       <= pwdata[11:0];
        tda_pkg::REG_SLICE_TILES:     cfg.slice_tiles     <= pwdata[22:0];
        tda_pkg::REG_TILE_SIZE_BYTES: cfg.tile_size_bytes <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      tda_pkg::REG_ELEMENT_BITS:    prdata = {24'd0, cfg.element_bits};
      tda_pkg::REG_MICRO_MODE:      prdata = {29'd0, cfg.micro_mode};
      tda_pkg::REG_ARRAY_CLASS:     prdata = {30'd0, cfg.array_class};
      tda_pkg::REG_TILE_DEPTH:      prdata = {29'd0, cfg.tile_depth};
      tda_pkg::REG_ROW_TILES:       prdata = {20'd0, cfg.row_tiles};
      tda_pkg::REG_SLICE_TILES:     prdata = {9'd0, cfg.slice_tiles};
      tda_pkg::REG_TILE_SIZE_BYTES: prdata = {18'd0, cfg.tile_size_bytes};
      default:                      prdata = '0;
    endcase
  end

endmodule

### rtl/tda_div.sv
`timescale 1ns / 1ps

// Three-stage restoring divider: 13-bit slice index by a 3-bit slice depth.
// Stage loads follow the pipeline's per-stage enables.
module tda_div (
  input  logic                       clk,
  input  logic [2:0]                 en,
  input  logic [tda_pkg::Z_W-1:0]    z,
  input  logic [2:0]                 d,
  output logic [tda_pkg::Z_W-1:0]    q
);

  logic [2:0] rem_a, rem_a_next;
  logic [4:0] q_a, q_a_next;
  logic [7:0] zl_a;
  logic [2:0] rem_b, rem_b_next;
  logic [8:0] q_b;
  logic [3:0] q_b_next;
  logic [3:0] zl_b;
  logic [3:0] q_c_next;

  // Quotient bits 12..8
  always_comb begin : step_a
    logic [2:0] r;
    logic [3:0] s;
    r = '0;
    for (int i = 4; i >= 0; i--) begin
      s = tda_pkg::div_step(r, z[8+i], d);
      q_a_next[i] = s[3];
      r = s[2:0];
    end
    rem_a_next = r;
  end

  // Quotient bits 7..4
  always_comb begin : step_b
    logic [2:0] r;
    logic [3:0] s;
    r = rem_a;
    for (int i = 3; i >= 0; i--) begin
      s = tda_pkg::div_step(r, zl_a[4+i], d);
      q_b_next[i] = s[3];
      r = s[2:0];
    end
    rem_b_next = r;
  end

  // Quotient bits 3..0
  always_comb begin : step_c
    logic [2:0] r;
    logic [3:0] s;
    r = rem_b;
    for (int i = 3; i >= 0; i--) begin
      s = tda_pkg::div_step(r, zl_b[i], d);
      q_c_next[i] = s[3];
      r = s[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_a <= rem_a_next;
      q_a   <= q_a_next;
      zl_a  <= z[7:0];
    end
    if (en[1]) begin
      rem_b <= rem_b_next;
      q_b   <= {q_a, q_b_next};
      zl_b  <= zl_a[3:0];
    end
    if (en[2]) begin
      q <= {q_b, q_c_next};
    end
  end

endmodule

### rtl/tiled_1d_element_address_core.sv
`timescale 1ns / 1ps

// 1D micro-tiled element address core. Each beat of (coord_x, coord_y, coord_z)
// yields one beat of bit_offset, byte_offset and bad_combination. The datapath
// is a seven-stage pipeline: slice divide (three stages, alongside the swizzle,
// the tile row/column sum and the tile multiply), then two slice multiplies,
// the base sum and the final element add. Throughput is one beat per clock while
// the output is not back-pressured, with per-stage valid bits so bubbles collapse
// under back-pressure. Configuration registers sit on an APB port at byte
// addresses 4*i and must only be written while the pipeline is empty.
module tiled_1d_element_address_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tda_pkg::ADDR_W-1:0]          paddr,
  input  logic [tda_pkg::DATA_W-1:0]          pwdata,
  output logic [tda_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tda_pkg::COORD_W-1:0]         coord_x,
  input  logic [tda_pkg::COORD_W-1:0]         coord_y,
  input  logic [tda_pkg::Z_W-1:0]             coord_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tda_pkg::BIT_OFF_W-1:0]       bit_offset,
  output logic [tda_pkg::BYTE_OFF_W-1:0]      byte_offset,
  output logic                                bad_combination
);

  tda_pkg::cfg_t cfg;
  logic [7:1]    vld;
  logic [8:1]    rdy;
  logic [2:0]    depth;
  logic [tda_pkg::Z_W-1:0] quo;
  tda_pkg::swz_t swz_next;

  // Stage 1
  tda_pkg::swz_t                 s1_swz;
  logic [22:0]                   s1_ym;
  logic [tda_pkg::TCOORD_W-1:0]  s1_xh;
  // Stage 2
  logic [23:0]                   s2_tl;
  logic [16:0]                   s2_p;
  logic                          s2_bad;
  // Stage 3
  logic [37:0]                   s3_tb;
  logic [16:0]                   s3_p;
  logic                          s3_bad;
  // Stage 4
  logic [35:0]                   s4_qs;
  logic [37:0]                   s4_tb;
  logic [16:0]                   s4_p;
  logic                          s4_bad;
  // Stage 5
  logic [47:0]                   s5_sb;
  logic [37:0]                   s5_tb;
  logic [16:0]                   s5_p;
  logic                          s5_bad;
  // Stage 6
  logic [47:0]                   s6_sum;
  logic [16:0]                   s6_p;
  logic                          s6_bad;
  // Stage 7 (output)
  logic [tda_pkg::BIT_OFF_W-1:0] s7_bit;
  logic                          s7_bad;

  tda_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign depth = (cfg.tile_depth == 3'd0) ? 3'd1 : cfg.tile_depth;

  tda_div u_div (
    .clk (clk),
    .en  (rdy[3:1]),
    .z   (coord_z),
    .d   (depth),
    .q   (quo)
  );

  // Per-stage ready: a stage takes a beat when empty or when it drains
  always_comb begin
    rdy[8] = out_ready;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign swz_next = tda_pkg::swizzle(coord_x[2:0], coord_y[2:0], coord_z[2:0],
                                     cfg.element_bits, cfg.micro_mode, cfg.array_class);

  // Datapath stages
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_swz <= swz_next;
      s1_ym  <= 23'(coord_y[13:3]) * 23'(cfg.row_tiles);
      s1_xh  <= coord_x[13:3];
    end
    if (rdy[2]) begin
      s2_tl  <= 24'(s1_ym) + 24'(s1_xh);
      s2_p   <= 17'(s1_swz.idx) * 17'(cfg.element_bits);
      s2_bad <= s1_swz.bad;
    end
    if (rdy[3]) begin
      s3_tb  <= 38'(s2_tl) * 38'(cfg.tile_size_bytes);
      s3_p   <= s2_p;
      s3_bad <= s2_bad;
    end
    if (rdy[4]) begin
      s4_qs  <= 36'(quo) * 36'(cfg.slice_tiles);
      s4_tb  <= s3_tb;
      s4_p   <= s3_p;
      s4_bad <= s3_bad;
    end
    if (rdy[5]) begin
      s5_sb  <= 48'(s4_qs) * 48'(cfg.tile_size_bytes);
      s5_tb  <= s4_tb;
      s5_p   <= s4_p;
      s5_bad <= s4_bad;
    end
    if (rdy[6]) begin
      s6_sum <= s5_sb + 48'(s5_tb);
      s6_p   <= s5_p;
      s6_bad <= s5_bad;
    end
    if (rdy[7]) begin
      s7_bit <= {s6_sum, 3'b000} + 51'(s6_p);
      s7_bad <= s6_bad;
    end
  end

  assign out_valid       = vld[7];
  assign bit_offset      = s7_bit;
  assign byte_offset     = s7_bit[50:3];
  assign bad_combination = s7_bad;

`ifndef SYNTHESIS
  // An empty output stage means the whole pipe can take a beat
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

  // Byte offset is the bit offset shifted by three
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_offset == bit_offset[50:3]))
    else $error("byte offset out of step with bit offset");

  // Rotated mode never flags a bad combination
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (cfg.micro_mode == tda_pkg::MODE_ROTATED)) |-> !bad_combination)
    else $error("rotated mode flagged as unsupported");
`endif

endmodule

### sim/tiled_1d_element_address_core_tb.sv
`timescale 1ns / 1ps

module tiled_1d_element_address_core_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_IDLE     = 11;
  localparam int MAX_REPORTS  = 40;
  localparam int HOLD_CYCLES  = 150;

  // Mode and class encodings the block has no name for
  localparam logic [2:0] MODE_RESERVED_HI = 3'd7;
  localparam logic [1:0] CLASS_RESERVED   = 2'd3;

  typedef struct packed {
    logic [tda_pkg::BIT_OFF_W-1:0]  bit_off;
    logic [tda_pkg::BYTE_OFF_W-1:0] byte_off;
    logic                           bad;
  } texel_addr_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [tda_pkg::ADDR_W-1:0]     paddr = '0;
  logic [tda_pkg::DATA_W-1:0]     pwdata = '0;
  logic [tda_pkg::DATA_W-1:0]     prdata;
  logic                           pready;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [tda_pkg::COORD_W-1:0]    coord_x = '0;
  logic [tda_pkg::COORD_W-1:0]    coord_y = '0;
  logic [tda_pkg::Z_W-1:0]        coord_z = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [tda_pkg::BIT_OFF_W-1:0]  bit_offset;
  logic [tda_pkg::BYTE_OFF_W-1:0] byte_offset;
  logic                           bad_combination;

  tda_pkg::cfg_t surf_cfg;
  texel_addr_t   pending_addrs[$];
  texel_addr_t   oldest;
  int            mismatches = 0;
  int            cycles = 0;
  bit            no_gaps = 1'b0;
  int            hold_off_len = 0;

  tiled_1d_element_address_core u_top (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .coord_x         (coord_x),
    .coord_y         (coord_y),
    .coord_z         (coord_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .bit_offset      (bit_offset),
    .byte_offset     (byte_offset),
    .bad_combination (bad_combination)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Expected address of one texel under the current surface settings
  function automatic texel_addr_t predict_address(input logic [13:0] x,
                                                  input logic [13:0] y,
                                                  input logic [12:0] z);
    texel_addr_t r;
    logic [8:0]  idx;
    logic        bad;
    logic        deep;
    logic        xdeep;
    logic [63:0] depth;
    logic [63:0] slice_base;
    logic [63:0] tile_base;
    logic [63:0] total;
    idx = '0;
    bad = 1'b0;
    deep = (surf_cfg.array_class == tda_pkg::CLASS_THICK) ||
           (surf_cfg.array_class == tda_pkg::CLASS_XTHICK);
    xdeep = (surf_cfg.array_class == tda_pkg::CLASS_XTHICK);
    unique case (surf_cfg.micro_mode)
      tda_pkg::MODE_DISPLAY: begin
        idx[0] = x[0];
        unique case (surf_cfg.element_bits)
          tda_pkg::ELEM_8: begin
            idx[1] = x[1]; idx[2] = x[2]; idx[3] = y[1]; idx[4] = y[0]; idx[5] = y[2];
          end
          tda_pkg::ELEM_16: begin
            idx[1] = x[1]; idx[2] = x[2]; idx[3] = y[0]; idx[4] = y[1]; idx[5] = y[2];
          end
          tda_pkg::ELEM_32: begin
            idx[1] = x[1]; idx[2] = y[0]; idx[3] = x[2]; idx[4] = y[1]; idx[5] = y[2];
          end
          tda_pkg::ELEM_64: begin
            idx[1] = y[0]; idx[2] = x[1]; idx[3] = x[2]; idx[4] = y[1]; idx[5] = y[2];
          end
          default: begin
            idx = '0;
            bad = 1'b1;
          end
        endcase
      end
      tda_pkg::MODE_THIN, tda_pkg::MODE_DEPTH: begin
        idx[5:0] = {y[2], x[2], y[1], x[1], y[0], x[0]};
        if (deep) idx[7:6] = z[1:0];
        if (xdeep) idx[8] = z[2];
      end
      tda_pkg::MODE_THICK: begin
        if (!deep) begin
          bad = 1'b1;
        end else begin
          // z2 lands at bit 8 even when the size is unsupported
          idx[8] = xdeep & z[2];
          idx[1:0] = {y[0], x[0]};
          idx[7:6] = {y[2], x[2]};
          unique case (surf_cfg.element_bits)
            tda_pkg::ELEM_8, tda_pkg::ELEM_16:   idx[5:2] = {z[1], z[0], y[1], x[1]};
            tda_pkg::ELEM_32:                    idx[5:2] = {z[1], y[1], z[0], x[1]};
            tda_pkg::ELEM_64, tda_pkg::ELEM_128: idx[5:2] = {z[1], y[1], x[1], z[0]};
            default: begin
              idx[7:0] = '0;
              bad = 1'b1;
            end
          endcase
        end
      end
      default: ;  // rotated and reserved modes: index 0, no flag
    endcase

    depth = (surf_cfg.tile_depth == '0) ? 64'd1 : 64'(surf_cfg.tile_depth);
    slice_base = (64'(z) / depth) * 64'(surf_cfg.slice_tiles)
                 * 64'(surf_cfg.tile_size_bytes);
    tile_base = (64'(y >> tda_pkg::TILE_SH) * 64'(surf_cfg.row_tiles)
                 + 64'(x >> tda_pkg::TILE_SH)) * 64'(surf_cfg.tile_size_bytes);
    total = (slice_base + tile_base) * 64'd8 + 64'(idx) * 64'(surf_cfg.element_bits);
    r.bit_off = total[50:0];
    r.byte_off = total[50:3];
    r.bad = bad;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want_v);
    if (mismatches < MAX_REPORTS) begin
      $display("tb: %s mismatch at cycle %0d: got 0x%0h, expected 0x%0h",
               what, cycles, got, want_v);
    end
    mismatches++;
  endtask

  // Result beats against the oldest outstanding prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_addrs.size() == 0) begin
        report_mismatch("unexpected beat", 64'(bit_offset), 64'd0);
      end else begin
        oldest = pending_addrs.pop_front();
        if (bit_offset !== oldest.bit_off) begin
          report_mismatch("bit_offset", 64'(bit_offset), 64'(oldest.bit_off));
        end
        if (byte_offset !== oldest.byte_off) begin
          report_mismatch("byte_offset", 64'(byte_offset), 64'(oldest.byte_off));
        end
        if (bad_combination !== oldest.bad) begin
          report_mismatch("bad_combination", 64'(bad_combination), 64'(oldest.bad));
        end
      end
    end
  end

  // Result sink: random stall per beat, or a long hold-off when one is requested
  initial begin : result_sink
    int stall;
    forever begin
      if (hold_off_len > 0) begin
        stall = hold_off_len;
        hold_off_len = 0;
      end else begin
        stall = no_gaps ? 0 : int'($urandom_range(0, MAX_IDLE));
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_texel(input logic [13:0] x, input logic [13:0] y,
                            input logic [12:0] z);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, MAX_IDLE));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    do @(posedge clk); while (!in_ready);
    pending_addrs.push_back(predict_address(x, y, z));
  endtask

  task automatic send_random_texel();
    send_texel(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
               13'($urandom_range(0, 8191)));
  endtask

  // Pipeline empty, sender idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then idle
  task automatic write_reg(input logic [2:0] reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_surface(input tda_pkg::cfg_t c);
    write_reg(tda_pkg::REG_ELEMENT_BITS, 32'(c.element_bits));
    write_reg(tda_pkg::REG_MICRO_MODE, 32'(c.micro_mode));
    write_reg(tda_pkg::REG_ARRAY_CLASS, 32'(c.array_class));
    write_reg(tda_pkg::REG_TILE_DEPTH, 32'(c.tile_depth));
    write_reg(tda_pkg::REG_ROW_TILES, 32'(c.row_tiles));
    write_reg(tda_pkg::REG_SLICE_TILES, 32'(c.slice_tiles));
    write_reg(tda_pkg::REG_TILE_SIZE_BYTES, 32'(c.tile_size_bytes));
    surf_cfg = c;
  endtask

  function automatic tda_pkg::cfg_t surface(input int eb, input logic [2:0] mode,
                                            input logic [1:0] cls, input int depth,
                                            input int rowt, input int slicet,
                                            input int tsb);
    tda_pkg::cfg_t c;
    c.element_bits = 8'(eb);
    c.micro_mode = mode;
    c.array_class = cls;
    c.tile_depth = 3'(depth);
    c.row_tiles = 12'(rowt);
    c.slice_tiles = 23'(slicet);
    c.tile_size_bytes = 14'(tsb);
    return c;
  endfunction

  // Mostly legal surfaces, with a share of odd sizes, modes and divisors
  function automatic tda_pkg::cfg_t random_surface();
    tda_pkg::cfg_t c;
    c.element_bits = 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                        : (32'(tda_pkg::ELEM_8) << $urandom_range(0, 4)));
    c.micro_mode = 3'(($urandom_range(0, 5) == 0)
                      ? $urandom_range(MODE_RESERVED_HI, tda_pkg::MODE_ROTATED + 1)
                      : $urandom_range(tda_pkg::MODE_DISPLAY, tda_pkg::MODE_ROTATED));
    c.array_class = 2'($urandom_range(0, 3));
    c.tile_depth = 3'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                      : ($urandom_range(0, 1) ? 1 : 4));
    c.row_tiles = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                      : $urandom_range(1, 64));
    c.slice_tiles = 23'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388607)
                        : $urandom_range(1, 4096));
    c.tile_size_bytes = 14'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                            : (64 << $urandom_range(0, 7)));
    return c;
  endfunction

  // One surface, two texels: all coordinate bits set, then a random one
  task automatic probe_surface(input tda_pkg::cfg_t c);
    wait_drained();
    set_surface(c);
    send_texel(14'h3fff, 14'h3fff, 13'h1fff);
    send_random_texel();
  endtask

  task automatic test_reset_surface();
    send_texel(14'd0, 14'd0, 13'd0);
    send_texel(14'h3fff, 14'h3fff, 13'h1fff);
    send_texel(14'h2a5, 14'h15a, 13'h0a5);
  endtask

  task automatic test_special_cases();
    // largest register values, then all zero
    probe_surface(surface(255, tda_pkg::MODE_THIN, tda_pkg::CLASS_XTHICK, 7, 4095,
                          8388607, 16383));
    probe_surface(surface(0, tda_pkg::MODE_DISPLAY, tda_pkg::CLASS_THIN, 0, 0, 0, 0));
    // display with an unsupported element size
    probe_surface(surface(int'(tda_pkg::ELEM_128), tda_pkg::MODE_DISPLAY,
                          tda_pkg::CLASS_THIN, 1, 3, 7, 256));
    // thick micro tiles on a thin array
    probe_surface(surface(int'(tda_pkg::ELEM_32), tda_pkg::MODE_THICK,
                          tda_pkg::CLASS_THIN, 4, 5, 9, 512));
    // thick, extra thick, unsupported size: only z2 survives
    probe_surface(surface(24, tda_pkg::MODE_THICK, tda_pkg::CLASS_XTHICK, 4, 2, 6, 1024));
    // rotated and reserved modes give index 0 without the flag
    probe_surface(surface(int'(tda_pkg::ELEM_64), tda_pkg::MODE_ROTATED,
                          tda_pkg::CLASS_THICK, 1, 4, 4, 2048));
    probe_surface(surface(int'(tda_pkg::ELEM_16), MODE_RESERVED_HI,
                          tda_pkg::CLASS_XTHICK, 4, 7, 3, 128));
    // reserved array class behaves as thin
    probe_surface(surface(int'(tda_pkg::ELEM_64), tda_pkg::MODE_THIN, CLASS_RESERVED,
                          1, 11, 13, 64));
    // zero tile depth divides by one
    probe_surface(surface(int'(tda_pkg::ELEM_32), tda_pkg::MODE_THICK,
                          tda_pkg::CLASS_THICK, 0, 6, 10, 8192));
  endtask

  task automatic test_random_surfaces();
    for (int phase = 0; phase < 24; phase++) begin
      wait_drained();
      if (phase == 0) begin
        set_surface(surface(int'(tda_pkg::ELEM_128), tda_pkg::MODE_THICK,
                            tda_pkg::CLASS_XTHICK, 4, 2048, 4194304, 8192));
      end else begin
        set_surface(random_surface());
      end
      no_gaps = (phase % 5 == 3);
      repeat (58) send_random_texel();
      no_gaps = 1'b0;
    end
  endtask

  // Sink holds off while the source keeps offering beats back to back
  task automatic test_backpressure();
    wait_drained();
    set_surface(random_surface());
    no_gaps = 1'b1;
    hold_off_len = HOLD_CYCLES;
    repeat (60) send_random_texel();
    no_gaps = 1'b0;
  endtask

  initial begin
    surf_cfg = surface(int'(tda_pkg::ELEM_32), tda_pkg::MODE_THIN, tda_pkg::CLASS_THIN,
                       1, 1, 1, 256);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_surface();
    test_special_cases();
    test_random_surfaces();
    test_backpressure();
    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### tiled_1d_element_address_core.f
rtl/tda_pkg.sv
rtl/tda_regs.sv
rtl/tda_div.sv
rtl/tiled_1d_element_address_core.sv
sim/tiled_1d_element_address_core_tb.sv
